[hdl/bmhq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared codes for the binary min-heap queue: request actions and result status.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam logic ACT_REMOVE = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage : bmhq_pkg
`default_nettype wire

[hdl/bmhq_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_req_if
// Request channel of the heap queue: action and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmhq_req_if #(
  parameter int KEY_WIDTH = 32
);
  import bmhq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        action;
  logic signed [KEY_WIDTH-1:0] key_in;

  modport source (output valid, output action, output key_in, input ready);
  modport sink   (input valid, input action, input key_in, output ready);
endinterface : bmhq_req_if
`default_nettype wire

[hdl/bmhq_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_rsp_if
// Result channel of the heap queue: removed key, status and fill count.
// ----------------------------------------------------------------------------
interface bmhq_rsp_if #(
  parameter int KEY_WIDTH = 32,
  parameter int CNT_W     = 9
);
  import bmhq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] key_out;
  status_t                     status;
  logic [CNT_W-1:0]            count_after;

  modport source (output valid, output key_out, output status, output count_after,
                  input ready);
  modport sink   (input valid, input key_out, input status, input count_after,
                  output ready);
endinterface : bmhq_rsp_if
`default_nettype wire

[hdl/bmhq_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_out_reg
// Result holding register: keeps one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module bmhq_out_reg
  import bmhq_pkg::*;
#(
  parameter int KEY_WIDTH = 32,
  parameter int CNT_W     = 9
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output      logic                        space,
  input  wire logic signed [KEY_WIDTH-1:0] key,
  input  wire status_t                     status,
  input  wire logic [CNT_W-1:0]            count,
  bmhq_rsp_if.source                       rsp
);

  logic                        full;
  logic signed [KEY_WIDTH-1:0] key_q;
  status_t                     status_q;
  logic [CNT_W-1:0]            count_q;

  assign space = !full || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (space) begin
      full <= push;
    end
    if (push && space) begin
      key_q    <= key;
      status_q <= status;
      count_q  <= count;
    end
  end

  assign rsp.valid       = full;
  assign rsp.key_out     = key_q;
  assign rsp.status      = status_q;
  assign rsp.count_after = count_q;

endmodule : bmhq_out_reg
`default_nettype wire

[hdl/binary_min_heap_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// Insert: the new key enters the next free slot and rises while its parent is larger.
// Remove: the root key is returned; the last key is put at the root and sinks while
// a smaller child lies below it, up to ~log2(depth) levels.
// Errors (remove from empty, insert into full) and a remove that empties skip sifting.
// One request at a time; a waiting result holds the next one off, and the single
// read port and shared comparator set the pace. Reset clears count and state only.
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-heap priority queue of signed keys with a sequenced sift-up/sift-down
// over one memory and one shared comparator.
// ----------------------------------------------------------------------------
module binary_min_heap_queue
  import bmhq_pkg::*;
#(
  parameter int HEAP_CAPACITY = 256,
  parameter int KEY_WIDTH     = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  bmhq_req_if.sink  req,
  bmhq_rsp_if.source rsp
);

  localparam int CNT_W  = $clog2(HEAP_CAPACITY + 1);
  localparam int ADDR_W = $clog2(HEAP_CAPACITY);
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam logic [CNT_W-1:0] CAP  = CNT_W'(HEAP_CAPACITY);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);

  typedef enum logic [3:0] {
    S_IDLE, S_UP_CMP, S_RM_LAST, S_RM_LOAD,
    S_DN_RDR, S_DN_SEL, S_DN_SWAP, S_DN_PUT, S_DONE
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            pos;
  logic [CNT_W-1:0]            ch;
  logic signed [KEY_WIDTH-1:0] e;
  logic signed [KEY_WIDTH-1:0] child;
  logic signed [KEY_WIDTH-1:0] res_key;
  status_t                     res_status;

  logic signed [KEY_WIDTH-1:0] mem [DEPTH];
  logic signed [KEY_WIDTH-1:0] rdata;
  logic [CNT_W-1:0]            rd_slot;
  logic [CNT_W-1:0]            wr_slot;
  logic signed [KEY_WIDTH-1:0] wr_data;
  logic                        wr_en;

  logic signed [KEY_WIDTH-1:0] cmp_a;
  logic signed [KEY_WIDTH-1:0] cmp_b;
  logic                        lt;

  logic [CNT_W:0]              ins_slot;
  logic [CNT_W:0]              ch_left;
  logic                        push;
  logic                        space;

  assign ins_slot = {1'b0, count} + {{CNT_W{1'b0}}, 1'b1};
  assign ch_left  = {ch, 1'b0};
  assign req.ready = (state == S_IDLE);
  assign push      = (state == S_DONE);

  // shared comparator
  always_comb begin
    unique case (state)
      S_DN_SEL: begin
        cmp_a = rdata;
        cmp_b = child;
      end
      S_DN_SWAP: begin
        cmp_a = child;
        cmp_b = e;
      end
      default: begin
        cmp_a = e;
        cmp_b = rdata;
      end
    endcase
  end
  assign lt = cmp_a < cmp_b;

  always_comb begin
    unique case (state)
      S_IDLE:    rd_slot = (req.action == ACT_INSERT) ? ins_slot[CNT_W:1] : ONE;
      S_UP_CMP:  rd_slot = pos >> 2;
      S_RM_LAST: rd_slot = count;
      S_RM_LOAD: rd_slot = TWO;
      S_DN_RDR:  rd_slot = ch + ONE;
      S_DN_SWAP: rd_slot = ch_left[CNT_W-1:0];
      default:   rd_slot = ONE;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_slot = pos;
    wr_data = e;
    unique case (state)
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (pos != ONE && lt) begin
          wr_data = rdata;
        end
      end
      S_DN_SWAP: begin
        wr_en = 1'b1;
        if (lt) begin
          wr_data = child;
        end
      end
      S_DN_PUT: wr_en = 1'b1;
      default:  wr_en = 1'b0;
    endcase
  end

  // heap store, slot s at address s-1
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ADDR_W'(wr_slot - ONE)] <= wr_data;
    end
    rdata <= mem[ADDR_W'(rd_slot - ONE)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            res_key    <= '0;
            res_status <= ST_OK;
            if (req.action == ACT_INSERT) begin
              if (count == CAP) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                count <= ins_slot[CNT_W-1:0];
                pos   <= ins_slot[CNT_W-1:0];
                e     <= req.key_in;
                state <= S_UP_CMP;
              end
            end else if (count == '0) begin
              res_status <= ST_EMPTY;
              state      <= S_DONE;
            end else begin
              state <= S_RM_LAST;
            end
          end
        end
        S_UP_CMP: begin
          // parent larger: pull it down and climb, else the key settles here
          if (pos != ONE && lt) begin
            pos <= pos >> 1;
          end else begin
            state <= S_DONE;
          end
        end
        S_RM_LAST: begin
          res_key <= rdata;
          count   <= count - ONE;
          state   <= S_RM_LOAD;
        end
        S_RM_LOAD: begin
          e   <= rdata;
          pos <= ONE;
          if (count >= TWO) begin
            ch    <= TWO;
            state <= S_DN_RDR;
          end else if (count == ONE) begin
            state <= S_DN_PUT;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_RDR: begin
          child <= rdata;
          state <= (ch != count) ? S_DN_SEL : S_DN_SWAP;
        end
        S_DN_SEL: begin
          // right child wins only when strictly smaller
          if (lt) begin
            child <= rdata;
            ch    <= ch + ONE;
          end
          state <= S_DN_SWAP;
        end
        S_DN_SWAP: begin
          if (lt) begin
            pos <= ch;
            if (ch_left <= {1'b0, count}) begin
              ch    <= ch_left[CNT_W-1:0];
              state <= S_DN_RDR;
            end else begin
              state <= S_DN_PUT;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_PUT: state <= S_DONE;
        S_DONE: begin
          if (space) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bmhq_out_reg #(
    .KEY_WIDTH (KEY_WIDTH),
    .CNT_W     (CNT_W)
  ) u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .space  (space),
    .key    (res_key),
    .status (res_status),
    .count  (count),
    .rsp    (rsp)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP)
    else $error("heap count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |-> (count == $past(count) + ONE || count == $past(count) - ONE))
    else $error("heap count moved by more than one");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    push && res_status == ST_FULL |-> count == CAP)
    else $error("full status with room left");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    push && res_status == ST_EMPTY |-> count == '0)
    else $error("empty status with keys held");

endmodule : binary_min_heap_queue
`default_nettype wire
